// ----- rtl/core/canonical_huffman_table_decoder_macros.svh -----
// Assertion macros used by the canonical Huffman table decoder top level.
`ifndef CANONICAL_HUFFMAN_TABLE_DECODER_MACROS_SVH
`define CANONICAL_HUFFMAN_TABLE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define CHTD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CHTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHTD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CHTD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/chtd_pkg.sv -----
// Shared types and constants of the canonical Huffman table decoder.
`timescale 1ns / 1ps
`default_nettype none
package chtd_pkg;
   localparam int MAX_SYMBOLS_DEF = 512;
   localparam int ACTION_W = 2;
   localparam int IDX_W    = 9;
   localparam int LEN_W    = 4;
   localparam int COUNT_W  = 10;
   localparam int WIN_W    = 16;
   localparam int SYM_W    = 9;

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BUILD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DECODE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [IDX_W-1:0]    symbol_index;
      logic [LEN_W-1:0]    code_length;
      logic [COUNT_W-1:0]  symbol_count;
      logic [WIN_W-1:0]    bit_window;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_link_type;

   typedef struct packed {
      logic pop;
      logic init_done;
   } back_status_type;
endpackage
`default_nettype wire

// ----- rtl/core/canonical_huffman_table_decoder.sv -----
// Top level of the canonical Huffman table decoder.
//
// Requests arrive on req_: tuser carries the action (load a code length,
// build the tables, decode one symbol); tdata carries the operands.
// Only a decode returns a response on rsp_, holding the symbol and the
// number of bits it used; loads, builds and action 3 return nothing.
// A two-entry request queue sits in front of the execution unit, so new
// requests are taken while a response waits on a stalled receiver.
// A load is written to the length memory as it leaves the queue. A decode
// goes from the queue through the window register, the limit compare, the
// index add with the symbol memory read, and the response state, one
// decode at a time. A build walks the length memory twice through its
// single port, once to count the lengths and once to fill the symbol table,
// and requests queue meanwhile. After reset, a clearing pass zeroes every
// address of both memories and req_tready stays low until it ends.
// A stalled response holds rsp_tdata; the queue fills and then req_tready
// drops.
`timescale 1ns / 1ps
`default_nettype none
`include "canonical_huffman_table_decoder_macros.svh"
module canonical_huffman_table_decoder #(
   parameter int MAX_SYMBOLS = chtd_pkg::MAX_SYMBOLS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // symbol_index[8:0], code_length[12:9], symbol_count[22:13], bit_window[38:23]
   input  wire logic [47:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // symbol[8:0], bits_used[12:9]
   output logic [15:0]      rsp_tdata
);
   chtd_pkg::queue_link_type  link;
   chtd_pkg::back_status_type status;

   chtd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .link       (link)
   );

   chtd_back #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .link       (link),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `CHTD_ASSERT_IMPL(a_bits_nonzero, clock, reset, rsp_tvalid, rsp_tdata[12:9] != 4'd0)
   `CHTD_ASSERT_IMPL(a_no_accept_in_init, clock, reset, !status.init_done, !req_tready)
   `CHTD_ASSERT_NEXT(a_queue_holds, clock, reset, link.valid && !status.pop, link.valid)
   `CHTD_ASSERT_IMPL(a_no_pop_while_resp, clock, reset, rsp_tvalid, !status.pop)
endmodule
`default_nettype wire

// ----- rtl/core/chtd_front.sv -----
// Front end: accepts requests, drops unused actions and queues the rest.
`timescale 1ns / 1ps
`default_nettype none
module chtd_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [47:0]                 req_tdata,
   input  wire logic [1:0]                  req_tuser,
   input  wire chtd_pkg::back_status_type   status,
   output chtd_pkg::queue_link_type         link
);
   chtd_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       take;
   chtd_pkg::item_type req_item;

   always_comb begin
      req_item.action       = req_tuser;
      req_item.symbol_index = req_tdata[8:0];
      req_item.code_length  = req_tdata[12:9];
      req_item.symbol_count = req_tdata[22:13];
      req_item.bit_window   = req_tdata[38:23];
   end

   assign req_tready = status.init_done && (fill_ff != 2'd2);
   // Action 3 does nothing, so it is accepted and never queued.
   assign push = req_tvalid && req_tready &&
                 (req_tuser == chtd_pkg::ACT_LOAD || req_tuser == chtd_pkg::ACT_BUILD ||
                  req_tuser == chtd_pkg::ACT_DECODE);
   assign take = status.pop && link.valid;
   assign fill_in = fill_ff + {1'b0, push} - {1'b0, take};

   assign link.valid = (fill_ff != 2'd0);
   assign link.item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (take) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/chtd_back.sv -----
// Back end: length and symbol memories, table build sequencer and decoder.
`timescale 1ns / 1ps
`default_nettype none
module chtd_back #(
   parameter int MAX_SYMBOLS = chtd_pkg::MAX_SYMBOLS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire chtd_pkg::queue_link_type   link,
   output chtd_pkg::back_status_type       status,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [15:0]                     rsp_tdata
);
   localparam int AW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   // The counter also steps through the fifteen code lengths, so it keeps at least four bits.
   localparam int CW    = ($clog2(MAX_SYMBOLS + 1) > 4) ? $clog2(MAX_SYMBOLS + 1) : 4;
   localparam int ACC_W = CW + 17;
   localparam int NW    = 17;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_COUNT, ST_COUNT_END, ST_LIMIT,
      ST_FILL, ST_FILL_END, ST_DECODE, ST_LOOKUP, ST_RESP
   } state_type;

   state_type state_ff;
   logic [CW-1:0]  ctr_ff;
   logic [CW-1:0]  size_ff;
   logic [CW-1:0]  active_ff;
   logic [CW-1:0]  counts_ff [16];
   logic [15:0]    limit_ff  [16];
   logic [CW-1:0]  start_ff  [16];
   logic [CW-1:0]  fpos_ff   [16];
   logic [ACC_W-1:0] acc_ff;
   logic           rdv_ff;
   logic [AW-1:0]  rd_idx_ff;
   logic [15:0]    win_ff;
   logic [3:0]     bits_ff;
   logic [16:0]    diff_ff;
   logic [CW-1:0]  base_ff;

   logic [chtd_pkg::LEN_W-1:0] len_mem [MAX_SYMBOLS];
   logic [chtd_pkg::SYM_W-1:0] sym_mem [MAX_SYMBOLS];
   logic [chtd_pkg::LEN_W-1:0] len_rd_ff;
   logic [chtd_pkg::SYM_W-1:0] sym_rd_ff;

   logic                        len_we;
   logic [AW-1:0]               len_addr;
   logic [chtd_pkg::LEN_W-1:0]  len_wdata;
   logic                        sym_we;
   logic [AW-1:0]               sym_waddr;
   logic [chtd_pkg::SYM_W-1:0]  sym_wdata;
   logic [AW-1:0]               sym_raddr;

   logic          pop;
   logic [10:0]   load_idx;
   logic [10:0]   count_ext;
   logic [CW-1:0] size_in;
   logic [3:0]    li;
   logic [ACC_W-1:0] acc_in;
   logic          sat;
   logic [3:0]    found;
   logic [CW-1:0] fill_p;
   logic          fill_we;
   logic [NW-1:0] n_val;
   logic          n_ok;
   logic [4:0]    shamt;
   logic [15:0]   win_m;

   assign pop = (state_ff == ST_IDLE) && link.valid;
   assign status.pop = pop;
   assign status.init_done = (state_ff != ST_INIT);

   assign load_idx  = 11'(link.item.symbol_index);
   assign count_ext = 11'(link.item.symbol_count);
   assign size_in   = (count_ext > 11'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : CW'(count_ext);

   // One step of the limit recurrence per cycle.
   assign li     = ctr_ff[3:0];
   assign acc_in = (acc_ff + ACC_W'(counts_ff[li])) << 1;
   assign sat    = (acc_in >> ({1'b0, li} + 5'd1)) != '0;

   // Shortest length whose limit lies above the window; fifteen otherwise.
   assign win_m = link.item.bit_window & 16'hfffe;
   always_comb begin
      found = 4'd15;
      for (int i = 14; i >= 1; i--) begin
         if (win_ff < limit_ff[i]) begin
            found = 4'(i);
         end
      end
   end

   assign shamt = 5'd16 - {1'b0, bits_ff};
   assign n_val = NW'(base_ff) + NW'(diff_ff[15:0] >> shamt);
   assign n_ok  = !diff_ff[16] && (n_val < NW'(active_ff)) && (n_val < NW'(MAX_SYMBOLS));

   assign fill_p  = fpos_ff[len_rd_ff];
   assign fill_we = (state_ff == ST_FILL || state_ff == ST_FILL_END) && rdv_ff &&
                    (len_rd_ff != '0) && (fill_p < CW'(MAX_SYMBOLS));

   always_comb begin
      len_we    = 1'b0;
      len_addr  = ctr_ff[AW-1:0];
      len_wdata = '0;
      if (state_ff == ST_INIT) begin
         len_we = 1'b1;
      end else if (pop && link.item.action == chtd_pkg::ACT_LOAD) begin
         len_we    = (load_idx < 11'(MAX_SYMBOLS));
         len_addr  = load_idx[AW-1:0];
         len_wdata = link.item.code_length;
      end
   end

   always_comb begin
      sym_we    = 1'b0;
      sym_waddr = ctr_ff[AW-1:0];
      sym_wdata = '0;
      if (state_ff == ST_INIT || state_ff == ST_COUNT) begin
         sym_we = 1'b1;
      end else if (fill_we) begin
         sym_we    = 1'b1;
         sym_waddr = fill_p[AW-1:0];
         sym_wdata = chtd_pkg::SYM_W'(rd_idx_ff);
      end
      sym_raddr = n_ok ? n_val[AW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_addr] <= len_wdata;
      end
      len_rd_ff <= len_mem[len_addr];
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_waddr] <= sym_wdata;
      end
      sym_rd_ff <= sym_mem[sym_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         ctr_ff    <= '0;
         size_ff   <= '0;
         active_ff <= '0;
         acc_ff    <= '0;
         rdv_ff    <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            counts_ff[i] <= '0;
            limit_ff[i]  <= '0;
            start_ff[i]  <= '0;
            fpos_ff[i]   <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_INIT: begin
               ctr_ff <= ctr_ff + 1'b1;
               if (ctr_ff == CW'(MAX_SYMBOLS - 1)) begin
                  ctr_ff   <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop) begin
                  if (link.item.action == chtd_pkg::ACT_BUILD) begin
                     size_ff  <= size_in;
                     ctr_ff   <= '0;
                     rdv_ff   <= 1'b0;
                     for (int i = 0; i < 16; i++) begin
                        counts_ff[i] <= '0;
                     end
                     state_ff <= ST_COUNT;
                  end else if (link.item.action == chtd_pkg::ACT_DECODE) begin
                     win_ff   <= win_m;
                     state_ff <= ST_DECODE;
                  end
               end
            end
            ST_COUNT, ST_COUNT_END: begin
               // Symbol table is cleared while the lengths are counted.
               if (rdv_ff && len_rd_ff != '0) begin
                  counts_ff[len_rd_ff] <= counts_ff[len_rd_ff] + 1'b1;
               end
               rdv_ff <= (ctr_ff < size_ff);
               ctr_ff <= ctr_ff + 1'b1;
               if (state_ff == ST_COUNT_END) begin
                  rdv_ff      <= 1'b0;
                  ctr_ff      <= CW'(1);
                  acc_ff      <= '0;
                  limit_ff[0] <= '0;
                  start_ff[0] <= '0;
                  fpos_ff[0]  <= '0;
                  state_ff    <= ST_LIMIT;
               end else if (ctr_ff == CW'(MAX_SYMBOLS - 1)) begin
                  state_ff <= ST_COUNT_END;
               end
            end
            ST_LIMIT: begin
               acc_ff       <= acc_in;
               limit_ff[li] <= sat ? 16'hFFFF : 16'(acc_in << (4'd15 - li));
               start_ff[li] <= start_ff[li - 4'd1] + counts_ff[li - 4'd1];
               fpos_ff[li]  <= start_ff[li - 4'd1] + counts_ff[li - 4'd1];
               ctr_ff       <= ctr_ff + 1'b1;
               if (li == 4'd15) begin
                  ctr_ff   <= '0;
                  state_ff <= ST_FILL;
               end
            end
            ST_FILL, ST_FILL_END: begin
               if (rdv_ff && len_rd_ff != '0) begin
                  fpos_ff[len_rd_ff] <= fill_p + 1'b1;
               end
               rd_idx_ff <= ctr_ff[AW-1:0];
               if (state_ff == ST_FILL_END) begin
                  rdv_ff    <= 1'b0;
                  active_ff <= size_ff;
                  state_ff  <= ST_IDLE;
               end else if (ctr_ff < size_ff) begin
                  rdv_ff <= 1'b1;
                  ctr_ff <= ctr_ff + 1'b1;
               end else begin
                  rdv_ff   <= 1'b0;
                  state_ff <= ST_FILL_END;
               end
            end
            ST_DECODE: begin
               bits_ff  <= found;
               diff_ff  <= {1'b0, win_ff} - {1'b0, limit_ff[found - 4'd1]};
               base_ff  <= start_ff[found];
               state_ff <= ST_LOOKUP;
            end
            ST_LOOKUP: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = {3'b000, bits_ff, sym_rd_ff};
endmodule
`default_nettype wire

// ----- dv/canonical_huffman_table_decoder_tb.sv -----
// Self-checking testbench of the canonical Huffman table decoder.
`timescale 1ns / 1ps
`default_nettype none
module canonical_huffman_table_decoder_tb;
   localparam int NSYM = chtd_pkg::MAX_SYMBOLS_DEF;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic [chtd_pkg::SYM_W-1:0] symbol;
      logic [3:0]                 bits_used;
   } decoded_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   canonical_huffman_table_decoder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow state of the decoder.
   logic [3:0]                 code_lengths [NSYM];
   logic [15:0]                limits [16];
   logic [9:0]                 starts [16];
   logic [chtd_pkg::SYM_W-1:0] symbols [NSYM];
   int unsigned                alphabet_size;

   chtd_pkg::item_type pending_requests [$];
   decoded_type        expected_symbols [$];
   int  error_count = 0;
   int  decodes_seen = 0;
   int  builds_sent = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   longint cycle_count = 0;

   task automatic rebuild_tables(input int unsigned count_in);
      int unsigned size, acc, m, p;
      int unsigned counts [16];
      int unsigned next_pos [16];
      size = (count_in > NSYM) ? NSYM : count_in;
      foreach (counts[i]) counts[i] = 0;
      foreach (symbols[i]) symbols[i] = '0;
      for (int i = 0; i < size; i++) counts[code_lengths[i]]++;
      counts[0] = 0;
      limits[0] = '0;
      starts[0] = '0;
      next_pos[0] = 0;
      acc = 0;
      for (int i = 1; i < 16; i++) begin
         acc = 2 * (acc + counts[i]);
         m = acc << (15 - i);
         limits[i] = (m > 32'hFFFF) ? 16'hFFFF : m[15:0];
         starts[i] = 10'(starts[i-1] + counts[i-1]);
         next_pos[i] = starts[i];
      end
      for (int i = 0; i < size; i++) begin
         if (code_lengths[i] != 0) begin
            p = next_pos[code_lengths[i]]++;
            if (p < NSYM) symbols[p] = i[chtd_pkg::SYM_W-1:0];
         end
      end
      alphabet_size = size;
   endtask

   function automatic decoded_type decode_window(input logic [15:0] raw);
      decoded_type r;
      int unsigned win, bits, n;
      win = raw & 16'hFFFE;
      bits = 15;
      for (int i = 1; i < 15; i++) begin
         if (win < limits[i]) begin
            bits = i;
            break;
         end
      end
      // Limits never decrease, so the window is never below the previous limit.
      n = starts[bits] + ((win - limits[bits-1]) >> (16 - bits));
      if (n >= alphabet_size || n >= NSYM) n = 0;
      r.symbol = symbols[n];
      r.bits_used = bits[3:0];
      return r;
   endfunction

   task automatic predict(input chtd_pkg::item_type it);
      case (it.action)
         chtd_pkg::ACT_LOAD: code_lengths[it.symbol_index] = it.code_length;
         chtd_pkg::ACT_BUILD: rebuild_tables(it.symbol_count);
         chtd_pkg::ACT_DECODE: expected_symbols.push_back(decode_window(it.bit_window));
         default: ;
      endcase
   endtask

   function automatic chtd_pkg::item_type make_item(input logic [1:0] act, input int idx,
                                                    input int len, input int cnt,
                                                    input int win);
      chtd_pkg::item_type it;
      it.action = act;
      it.symbol_index = idx[chtd_pkg::IDX_W-1:0];
      it.code_length = len[chtd_pkg::LEN_W-1:0];
      it.symbol_count = cnt[chtd_pkg::COUNT_W-1:0];
      it.bit_window = win[chtd_pkg::WIN_W-1:0];
      return it;
   endfunction

   // Driver: holds the request until it is taken, then predicts it.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) predict(pending_requests.pop_front());
         if (req_tvalid && !req_tready) begin
            // Hold the current request.
         end else if (pending_requests.size() != 0 &&
                      $urandom_range(99, 0) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_requests[0].action;
            req_tdata <= {9'd0, pending_requests[0].bit_window,
                          pending_requests[0].symbol_count,
                          pending_requests[0].code_length,
                          pending_requests[0].symbol_index};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each response against the oldest prediction.
   always @(posedge clock) begin
      decoded_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            decodes_seen++;
            if (expected_symbols.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_tdata[8:0] !== want.symbol) begin
                  $error("symbol: expected %0d, got %0d", want.symbol, rsp_tdata[8:0]);
                  error_count++;
               end
               if (rsp_tdata[12:9] !== want.bits_used) begin
                  $error("bits_used: expected %0d, got %0d", want.bits_used,
                         rsp_tdata[12:9]);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("canonical_huffman_table_decoder_tb: errors");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_symbols.size() != 0)
         @(posedge clock);
   endtask

   // A random code: lengths of zero or 1 to max_len on an alphabet of the given size, then a build.
   task automatic queue_alphabet(input int size, input int max_len);
      for (int s = 0; s < size; s++)
         pending_requests.push_back(make_item(chtd_pkg::ACT_LOAD, s,
            ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(max_len, 1), 0, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_BUILD, 0, 0, size, 0));
      builds_sent++;
   endtask

   initial begin
      int phase_idle [4] = '{0, 46, 0, 14};
      int phase_stall [4] = '{0, 0, 46, 14};
      int sent, sz;
      foreach (code_lengths[i]) code_lengths[i] = '0;
      foreach (symbols[i]) symbols[i] = '0;
      foreach (limits[i]) limits[i] = '0;
      foreach (starts[i]) starts[i] = '0;
      alphabet_size = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: decode before any build, unused action, extremes, and
      // oversized, zero and full builds.
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'hFFFF));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_UNUSED, 511, 15, 1023, 16'hFFFF));
      pending_requests.push_back(make_item(chtd_pkg::ACT_LOAD, 0, 1, 0, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_LOAD, 1, 2, 0, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_LOAD, 2, 15, 0, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_LOAD, 511, 15, 0, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_BUILD, 0, 0, 1023, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'h0000));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'h8001));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'hC000));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'hFFFF));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'hFFFE));
      pending_requests.push_back(make_item(chtd_pkg::ACT_BUILD, 0, 0, 0, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'h5555));
      pending_requests.push_back(make_item(chtd_pkg::ACT_BUILD, 0, 0, 512, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'hAAAA));
      pending_requests.push_back(make_item(chtd_pkg::ACT_BUILD, 0, 0, 3, 0));
      pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE, 0, 0, 0, 16'h7FFF));
      builds_sent += 4;
      wait_drained();

      sent = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_idle[ph];
         recv_stall_pct = phase_stall[ph];
         while (sent < (ph + 1) * 430) begin
            case ($urandom_range(9, 0))
               0: begin
                  // Noise: stray loads anywhere, odd builds, decodes, unused action.
                  pending_requests.push_back(make_item(2'($urandom_range(3, 0)),
                     $urandom_range(511, 0), $urandom_range(15, 0),
                     $urandom_range(1023, 0), $urandom_range(65535, 0)));
                  if (pending_requests[$].action == chtd_pkg::ACT_BUILD) builds_sent++;
                  sent++;
               end
               1, 2: begin
                  sz = ($urandom_range(15, 0) == 0) ? $urandom_range(512, 2)
                                                    : $urandom_range(24, 2);
                  queue_alphabet(sz, ($urandom_range(1, 0) != 0) ? 15 : 6);
                  sent += sz + 1;
               end
               default: begin
                  for (int k = 0; k < 8; k++)
                     pending_requests.push_back(make_item(chtd_pkg::ACT_DECODE,
                        $urandom_range(511, 0), $urandom_range(15, 0),
                        $urandom_range(1023, 0), $urandom_range(65535, 0)));
                  sent += 8;
               end
            endcase
            while (pending_requests.size() > 64) @(posedge clock);
         end
         wait_drained();
         // A build may still be walking the tables after the last response.
         repeat (1100) @(posedge clock);
      end

      $display("Sent %0d requests with %0d builds; %0d decodes checked over four",
               sent + 19, builds_sent, decodes_seen);
      $display("handshake pressure phases.");
      if (error_count == 0) begin
         $display("canonical_huffman_table_decoder_tb: clean");
      end else begin
         $display("canonical_huffman_table_decoder_tb: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
